FILE: sv/text_console_writer_defines.svh
// Assertion macros shared by the text console writer RTL
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH
`ifndef SYNTHESIS
`define TCW_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TCW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCW_ASSERT(lbl, clk, rst, prop, msg)
`define TCW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: sv/tcw_pkg.sv
// Types and constants shared by the text console writer modules
package tcw_pkg;

  localparam int MAX_COLS_DEF = 128;
  localparam int MAX_ROWS_DEF = 32;

  localparam logic [7:0] COLS_RST = 8'd80;
  localparam logic [5:0] ROWS_RST = 6'd25;
  localparam logic [7:0] FG_RST   = 8'h00;
  localparam logic [7:0] BG_RST   = 8'h0f;

  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_BLANK = 8'd0;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLS,
    REG_ROWS,
    REG_FG,
    REG_BG
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MODE_WRITE,
    MODE_CLEAR,
    MODE_CLEAR_LINE,
    MODE_SCROLL,
    MODE_SET_CURSOR,
    MODE_READ
  } mode_t;

  typedef struct packed {
    logic [7:0] cols;
    logic [5:0] rows;
    logic [7:0] fg;
    logic [7:0] bg;
  } cfg_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] fg;
    logic [7:0] bg;
  } cell_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUT1,
    ST_PUT2,
    ST_CPY_RD,
    ST_CPY_WR,
    ST_BLANK,
    ST_RESP
  } state_t;

endpackage

FILE: sv/text_console_writer.sv
// Text console writer top level: configuration registers, sequencer and cell store
// One command is taken when start is high and busy is low; exactly one result beat follows,
// marked by done for a single cycle, and it cannot be held off. Set cursor, unused modes and
// out-of-range line clears go straight to the result beat, as does read cell, whose cell
// store read is registered. A character write puts one cell (a tab that fits two cells puts
// both, a newline none). Clear line blanks one row, clear screen every row of the window, and
// scroll by n (taken as h above h) copies the rows below the top n up by n and blanks the
// bottom n rows, a zero count doing nothing, where h is the window height; a character that
// runs off the bottom row adds a scroll by one. The sequencer walks the single write port and
// single read port of the cell store one cell per cycle, a read then a write per moved cell.
module text_console_writer import tcw_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output logic                 done,
  input  logic [2:0]           mode,
  input  logic [7:0]           char_code,
  input  logic [5:0]           line_count,
  input  logic [6:0]           col,
  input  logic [4:0]           row,
  output logic [6:0]           cursor_col,
  output logic [4:0]           cursor_row,
  output logic [7:0]           cell_char,
  output logic [7:0]           cell_fg,
  output logic [7:0]           cell_bg,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(MAX_COLS * MAX_ROWS);

  cfg_t          cfg;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  cell_t         mem_wdata, mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{cols: COLS_RST, rows: ROWS_RST, fg: FG_RST, bg: BG_RST};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COLS: cfg.cols <= cfg_data;
        REG_ROWS: cfg.rows <= cfg_data[5:0];
        REG_FG:   cfg.fg   <= cfg_data;
        REG_BG:   cfg.bg   <= cfg_data;
      endcase
    end
  end

  tcw_ctrl #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .AW       (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .mode       (mode),
    .char_code  (char_code),
    .line_count (line_count),
    .col        (col),
    .row        (row),
    .busy       (busy),
    .done       (done),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .cell_char  (cell_char),
    .cell_fg    (cell_fg),
    .cell_bg    (cell_bg),
    .cfg        (cfg),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  tcw_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

FILE: sv/tcw_mem.sv
// Cell store: one write port and one registered read port
module tcw_mem import tcw_pkg::*; #(
  parameter int DEPTH = MAX_COLS_DEF * MAX_ROWS_DEF,
  parameter int AW    = $clog2(MAX_COLS_DEF * MAX_ROWS_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  cell_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output cell_t         rdata
);

  cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/tcw_ctrl.sv
// Command sequencer: cursor, row and column counters and cell store address generation
`include "text_console_writer_defines.svh"
module tcw_ctrl import tcw_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int AW       = $clog2(MAX_COLS_DEF * MAX_ROWS_DEF)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [2:0]    mode,
  input  logic [7:0]    char_code,
  input  logic [5:0]    line_count,
  input  logic [6:0]    col,
  input  logic [4:0]    row,
  output logic          busy,
  output logic          done,
  output logic [6:0]    cursor_col,
  output logic [4:0]    cursor_row,
  output logic [7:0]    cell_char,
  output logic [7:0]    cell_fg,
  output logic [7:0]    cell_bg,
  input  cfg_t          cfg,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output cell_t         mem_wdata,
  output logic          mem_re,
  output logic [AW-1:0] mem_raddr,
  input  cell_t         mem_rdata
);

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int DEPTH = MAX_COLS * MAX_ROWS;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    cell_addr = AW'(r) * AW'(MAX_COLS) + AW'(c);
  endfunction

  state_t        state, state_next, after_put, after_put_next;
  logic [CW-1:0] cur_c, cur_c_next, cc, cc_next, wr_c, wr_c_next;
  logic [RW-1:0] cur_r, cur_r_next, rc, rc_next, last, last_next;
  logic [RW-1:0] nsh, nsh_next, wr_r, wr_r_next, src_r;
  logic [7:0]    wr_ch, wr_ch_next;
  logic          tab2, tab2_next, rd_mode, rd_mode_next;

  logic [CW-1:0] wm1, cx, ic;
  logic [RW-1:0] hm1, cy, ir;
  logic [CW:0]   nc;
  logic          is_nl, is_tab, wrap, at_bottom;
  cell_t         blank_cell, put_cell;

  always_comb begin
    if (cfg.cols == '0) begin
      wm1 = '0;
    end else if (9'(cfg.cols) > 9'(MAX_COLS)) begin
      wm1 = CW'(MAX_COLS - 1);
    end else begin
      wm1 = CW'(cfg.cols - 8'd1);
    end
    if (cfg.rows == '0) begin
      hm1 = '0;
    end else if (7'(cfg.rows) > 7'(MAX_ROWS)) begin
      hm1 = RW'(MAX_ROWS - 1);
    end else begin
      hm1 = RW'(cfg.rows - 6'd1);
    end
  end

  assign cx        = (cur_c > wm1) ? wm1 : cur_c;
  assign cy        = (cur_r > hm1) ? hm1 : cur_r;
  assign ic        = (9'(col) > 9'(wm1)) ? wm1 : CW'(col);
  assign ir        = (7'(row) > 7'(hm1)) ? hm1 : RW'(row);
  assign is_nl     = (char_code == CHAR_NL);
  assign is_tab    = (char_code == CHAR_TAB);
  assign nc        = {1'b0, cx} + (is_tab ? (CW+1)'(2) : (CW+1)'(1));
  assign wrap      = is_nl || (nc > {1'b0, wm1});
  assign at_bottom = (cy == hm1);
  assign src_r     = rc + nsh;
  assign blank_cell = '{ch: CHAR_BLANK, fg: cfg.fg, bg: cfg.bg};
  assign put_cell   = '{ch: wr_ch, fg: cfg.fg, bg: cfg.bg};

  always_comb begin
    state_next     = state;
    after_put_next = after_put;
    cur_c_next     = cur_c;
    cur_r_next     = cur_r;
    cc_next        = cc;
    rc_next        = rc;
    last_next      = last;
    nsh_next       = nsh;
    wr_c_next      = wr_c;
    wr_r_next      = wr_r;
    wr_ch_next     = wr_ch;
    tab2_next      = tab2;
    rd_mode_next   = rd_mode;
    mem_we         = 1'b0;
    mem_waddr      = cell_addr(rc, cc);
    mem_wdata      = blank_cell;
    mem_re         = 1'b0;
    mem_raddr      = cell_addr(src_r, cc);
    done           = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cur_c_next   = cx;
          cur_r_next   = cy;
          rd_mode_next = 1'b0;
          rc_next      = '0;
          cc_next      = '0;
          last_next    = hm1;
          state_next   = ST_RESP;
          unique case (mode)
            MODE_WRITE: begin
              wr_c_next  = cx;
              wr_r_next  = cy;
              wr_ch_next = is_tab ? CHAR_SPACE : char_code;
              tab2_next  = is_tab && (cx != wm1);
              if (wrap) begin
                cur_c_next = '0;
                cur_r_next = at_bottom ? cy : cy + RW'(1);
              end else begin
                cur_c_next = CW'(nc);
              end
              nsh_next = RW'(1);
              if (wrap && at_bottom) begin
                after_put_next = (hm1 == '0) ? ST_BLANK : ST_CPY_RD;
              end else begin
                after_put_next = ST_RESP;
              end
              if (is_nl) begin
                state_next = (wrap && at_bottom) ?
                             ((hm1 == '0) ? ST_BLANK : ST_CPY_RD) : ST_RESP;
              end else begin
                state_next = ST_PUT1;
              end
            end
            MODE_CLEAR: begin
              state_next = ST_BLANK;
            end
            MODE_CLEAR_LINE: begin
              if (7'(line_count) <= 7'(hm1)) begin
                rc_next    = RW'(line_count);
                last_next  = RW'(line_count);
                state_next = ST_BLANK;
              end
            end
            MODE_SCROLL: begin
              if (line_count == '0) begin
                state_next = ST_RESP;
              end else if (7'(line_count) > 7'(hm1)) begin
                state_next = ST_BLANK;
              end else begin
                nsh_next   = RW'(line_count);
                state_next = ST_CPY_RD;
              end
            end
            MODE_SET_CURSOR: begin
              cur_c_next = ic;
              cur_r_next = ir;
            end
            MODE_READ: begin
              rd_mode_next = 1'b1;
              mem_re       = 1'b1;
              mem_raddr    = cell_addr(ir, ic);
            end
            default: begin
              state_next = ST_RESP;
            end
          endcase
        end
      end
      ST_PUT1: begin
        mem_we     = 1'b1;
        mem_waddr  = cell_addr(wr_r, wr_c);
        mem_wdata  = put_cell;
        state_next = tab2 ? ST_PUT2 : after_put;
      end
      ST_PUT2: begin
        mem_we     = 1'b1;
        mem_waddr  = cell_addr(wr_r, wr_c + CW'(1));
        mem_wdata  = put_cell;
        state_next = after_put;
      end
      ST_CPY_RD: begin
        mem_re     = 1'b1;
        state_next = ST_CPY_WR;
      end
      ST_CPY_WR: begin
        mem_we     = 1'b1;
        mem_wdata  = mem_rdata;
        state_next = ST_CPY_RD;
        if (cc == wm1) begin
          cc_next = '0;
          rc_next = rc + RW'(1);
          if (src_r == hm1) begin
            last_next  = hm1;
            state_next = ST_BLANK;
          end
        end else begin
          cc_next = cc + CW'(1);
        end
      end
      ST_BLANK: begin
        mem_we = 1'b1;
        if (cc == wm1) begin
          cc_next = '0;
          if (rc == last) begin
            state_next = ST_RESP;
          end else begin
            rc_next = rc + RW'(1);
          end
        end else begin
          cc_next = cc + CW'(1);
        end
      end
      ST_RESP: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cur_c <= '0;
      cur_r <= '0;
    end else begin
      state <= state_next;
      cur_c <= cur_c_next;
      cur_r <= cur_r_next;
    end
  end

  always_ff @(posedge clk) begin
    after_put <= after_put_next;
    cc        <= cc_next;
    rc        <= rc_next;
    last      <= last_next;
    nsh       <= nsh_next;
    wr_c      <= wr_c_next;
    wr_r      <= wr_r_next;
    wr_ch     <= wr_ch_next;
    tab2      <= tab2_next;
    rd_mode   <= rd_mode_next;
  end

  assign busy       = (state != ST_IDLE);
  assign cursor_col = 7'(cur_c);
  assign cursor_row = 5'(cur_r);
  assign cell_char  = rd_mode ? mem_rdata.ch : '0;
  assign cell_fg    = rd_mode ? mem_rdata.fg : '0;
  assign cell_bg    = rd_mode ? mem_rdata.bg : '0;

  `TCW_ASSERT(a_done_then_idle, clk, rst, done |=> !busy, "busy after result beat")
  `TCW_ASSERT(a_waddr_range, clk, rst, mem_we |-> (32'(mem_waddr) < 32'(DEPTH)), "write outside store")
  `TCW_ASSERT(a_cursor_in_window, clk, rst, done |-> (cur_c <= wm1 && cur_r <= hm1), "cursor outside window")
  `TCW_ASSERT(a_copy_src_in_window, clk, rst, (state == ST_CPY_RD) |-> (src_r <= hm1), "scroll source row outside window")

endmodule

FILE: tb/console_checker.sv
// Checker for the text console writer: mirrors the cell store and cursor, compares result beats
module console_checker import tcw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 done,
  input  logic [2:0]           mode,
  input  logic [7:0]           char_code,
  input  logic [5:0]           line_count,
  input  logic [6:0]           col,
  input  logic [4:0]           row,
  input  logic [6:0]           cursor_col,
  input  logic [4:0]           cursor_row,
  input  logic [7:0]           cell_char,
  input  logic [7:0]           cell_fg,
  input  logic [7:0]           cell_bg,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_C = MAX_COLS_DEF;
  localparam int unsigned MAX_R = MAX_ROWS_DEF;

  typedef struct packed {
    logic [6:0] cc;
    logic [4:0] cr;
    cell_t      slot;
  } report_t;

  cell_t      screen [MAX_C*MAX_R];
  logic [6:0] cur_c;
  logic [4:0] cur_r;
  cfg_t       cfg;
  report_t    due_reports [$];
  report_t    want;

  function automatic int unsigned win_w();
    if (cfg.cols == 8'd0) return 1;
    if (cfg.cols > MAX_C) return MAX_C;
    return int'(cfg.cols);
  endfunction

  function automatic int unsigned win_h();
    if (cfg.rows == 6'd0) return 1;
    if (cfg.rows > MAX_R) return MAX_R;
    return int'(cfg.rows);
  endfunction

  function automatic void paint(int unsigned c, int unsigned r, logic [7:0] ch);
    if (c < MAX_C && r < MAX_R) screen[r*MAX_C + c] = '{ch, cfg.fg, cfg.bg};
  endfunction

  function automatic void blank_line(int unsigned r, int unsigned w);
    for (int unsigned c = 0; c < w; c++) paint(c, r, CHAR_BLANK);
  endfunction

  function automatic void roll_up(int unsigned n, int unsigned w, int unsigned h);
    int unsigned k;
    k = (n > h) ? h : n;
    if (k == 0) return;
    for (int unsigned r = 0; r + k < h; r++)
      for (int unsigned c = 0; c < w; c++)
        screen[r*MAX_C + c] = screen[(r + k)*MAX_C + c];
    for (int unsigned r = h - k; r < h; r++) blank_line(r, w);
  endfunction

  function automatic report_t run_console_cmd(logic [2:0] md, logic [7:0] ch,
                                              logic [5:0] cnt, logic [6:0] ic,
                                              logic [4:0] ir);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int unsigned sc;
    int unsigned sr;
    report_t     rep;
    w   = win_w();
    h   = win_h();
    c   = (cur_c > w - 1) ? w - 1 : cur_c;
    r   = (cur_r > h - 1) ? h - 1 : cur_r;
    sc  = (ic > w - 1) ? w - 1 : ic;
    sr  = (ir > h - 1) ? h - 1 : ir;
    rep = '0;
    case (mode_t'(md))
      MODE_WRITE: begin
        if (ch == CHAR_NL) begin
          r++;
          c = 0;
        end else if (ch == CHAR_TAB) begin
          paint(c, r, CHAR_SPACE);
          if (c + 1 < w) paint(c + 1, r, CHAR_SPACE);
          c += 2;
        end else begin
          paint(c, r, ch);
          c++;
        end
        if (c >= w) begin
          r++;
          c = 0;
        end
        if (r >= h) begin
          r = h - 1;
          c = 0;
          roll_up(1, w, h);
        end
      end
      MODE_CLEAR: begin
        for (int unsigned k = 0; k < h; k++) blank_line(k, w);
      end
      MODE_CLEAR_LINE: begin
        if (cnt < h) blank_line(cnt, w);
      end
      MODE_SCROLL: roll_up(cnt, w, h);
      MODE_SET_CURSOR: begin
        c = sc;
        r = sr;
      end
      MODE_READ: rep.slot = screen[sr*MAX_C + sc];
      default: ;
    endcase
    cur_c  = c[6:0];
    cur_r  = r[4:0];
    rep.cc = cur_c;
    rep.cr = cur_r;
    return rep;
  endfunction

  task automatic flag_mismatch(string what, logic [7:0] got, logic [7:0] exp_v);
    fail_count++;
    $display("%0t: %s: got 0x%h, want 0x%h", $realtime, what, got, exp_v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cur_c      = '0;
      cur_r      = '0;
      cfg        = '{COLS_RST, ROWS_RST, FG_RST, BG_RST};
      fail_count = 0;
      due_reports.delete();
    end else begin
      if (done) begin
        if (due_reports.size() == 0) begin
          flag_mismatch("result beat with nothing due", {1'b0, cursor_col}, 8'h00);
        end else begin
          want = due_reports.pop_front();
          if (cursor_col !== want.cc) flag_mismatch("cursor_col", {1'b0, cursor_col},
                                                    {1'b0, want.cc});
          if (cursor_row !== want.cr) flag_mismatch("cursor_row", {3'b0, cursor_row},
                                                    {3'b0, want.cr});
          if (cell_char !== want.slot.ch) flag_mismatch("cell_char", cell_char, want.slot.ch);
          if (cell_fg !== want.slot.fg) flag_mismatch("cell_fg", cell_fg, want.slot.fg);
          if (cell_bg !== want.slot.bg) flag_mismatch("cell_bg", cell_bg, want.slot.bg);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_COLS: cfg.cols = cfg_data;
          REG_ROWS: cfg.rows = cfg_data[5:0];
          REG_FG:   cfg.fg   = cfg_data;
          REG_BG:   cfg.bg   = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy)
        due_reports.push_back(run_console_cmd(mode, char_code, line_count, col, row));
    end
    pending = due_reports.size();
  end

endmodule

FILE: tb/tb_text_console_writer.sv
// Testbench top for the text console writer: clock, reset, command and register stimulus, verdict
module tb_text_console_writer;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;
  localparam int         QUIET_LIMIT  = 40000;
  localparam int         GAP_PCT      = 37;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] ch;
    logic [5:0] cnt;
    logic [6:0] c;
    logic [4:0] r;
  } cmd_t;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       start      = 1'b0;
  logic       busy;
  logic       done;
  logic [2:0] mode       = MODE_WRITE;
  logic [7:0] char_code  = '0;
  logic [5:0] line_count = '0;
  logic [6:0] col        = '0;
  logic [4:0] row        = '0;
  logic [6:0] cursor_col;
  logic [4:0] cursor_row;
  logic [7:0] cell_char;
  logic [7:0] cell_fg;
  logic [7:0] cell_bg;
  logic       cfg_valid  = 1'b0;
  logic       cfg_ready;
  cfg_reg_t   cfg_index  = REG_COLS;
  logic [7:0] cfg_data   = '0;
  int         fail_count;
  int         pending;
  int         quiet_cycles = 0;

  text_console_writer dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .mode(mode), .char_code(char_code), .line_count(line_count), .col(col), .row(row),
    .cursor_col(cursor_col), .cursor_row(cursor_row),
    .cell_char(cell_char), .cell_fg(cell_fg), .cell_bg(cell_bg),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  console_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .mode(mode), .char_code(char_code), .line_count(line_count), .col(col), .row(row),
    .cursor_col(cursor_col), .cursor_row(cursor_row),
    .cell_char(cell_char), .cell_fg(cell_fg), .cell_bg(cell_bg),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("text_console_writer: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic cmd_t mk(logic [2:0] md, logic [7:0] ch, logic [5:0] cnt,
                              logic [6:0] c, logic [4:0] r);
    return '{md, ch, cnt, c, r};
  endfunction

  function automatic cmd_t pick(int unsigned w, int unsigned h, bit big);
    cmd_t        k;
    int unsigned roll;
    int unsigned sub;
    k.ch  = 8'($urandom_range(255));
    k.cnt = ($urandom_range(1) == 0) ? 6'($urandom_range(h + 1)) : 6'($urandom_range(63));
    k.c   = ($urandom_range(9) < 7) ? 7'($urandom_range(w - 1)) : 7'($urandom_range(127));
    k.r   = ($urandom_range(9) < 7) ? 5'($urandom_range(h - 1)) : 5'($urandom_range(31));
    roll  = $urandom_range(99);
    if (big) begin
      if (roll < 60) k.mode = MODE_WRITE;
      else if (roll < 62) k.mode = MODE_CLEAR_LINE;
      else if (roll < 64) k.mode = MODE_SCROLL;
      else if (roll < 80) k.mode = MODE_SET_CURSOR;
      else if (roll < 97) k.mode = MODE_READ;
      else if (roll < 99) k.mode = MODE_SPARE_A;
      else k.mode = MODE_SPARE_B;
    end else begin
      if (roll < 40) k.mode = MODE_WRITE;
      else if (roll < 48) k.mode = MODE_CLEAR_LINE;
      else if (roll < 53) k.mode = MODE_SCROLL;
      else if (roll < 56) k.mode = MODE_CLEAR;
      else if (roll < 66) k.mode = MODE_SET_CURSOR;
      else if (roll < 94) k.mode = MODE_READ;
      else if (roll < 97) k.mode = MODE_SPARE_A;
      else k.mode = MODE_SPARE_B;
    end
    if (k.mode == MODE_WRITE) begin
      sub = $urandom_range(99);
      if (sub < (big ? 3 : 15)) k.ch = CHAR_NL;
      else if (sub < (big ? 13 : 30)) k.ch = CHAR_TAB;
    end
    return k;
  endfunction

  task automatic send(cmd_t k, bit gaps);
    if (gaps && $urandom_range(99) < GAP_PCT) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start      <= 1'b1;
    mode       <= k.mode;
    char_code  <= k.ch;
    line_count <= k.cnt;
    col        <= k.c;
    row        <= k.r;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
  endtask

  task automatic put_reg(cfg_reg_t idx, logic [7:0] v, bit gaps);
    if (gaps && $urandom_range(99) < GAP_PCT) begin
      cfg_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic run_phase(logic [7:0] c, logic [7:0] r, logic [7:0] f, logic [7:0] b,
                           int n, bit big, bit steady, bit hold_mid);
    int unsigned w;
    int unsigned h;
    w = (c == 8'd0) ? 1 : (c > MAX_COLS_DEF) ? MAX_COLS_DEF : c;
    h = (r[5:0] == 6'd0) ? 1 : (r[5:0] > MAX_ROWS_DEF) ? MAX_ROWS_DEF : r[5:0];
    drain();
    put_reg(REG_COLS, c, !steady);
    put_reg(REG_ROWS, r, !steady);
    put_reg(REG_FG, f, !steady);
    put_reg(REG_BG, b, !steady);
    cfg_valid <= 1'b0;
    @(negedge clk);
    send(mk(MODE_CLEAR, 8'($urandom_range(255)), 6'($urandom_range(63)),
            7'($urandom_range(127)), 5'($urandom_range(31))), !steady);
    for (int i = 0; i < n; i++) begin
      if (hold_mid && i == n / 2) drain();
      send(pick(w, h, big), !steady);
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send(mk(MODE_CLEAR, 8'h00, 6'd0, 7'd0, 5'd0), 1'b1);
    send(mk(MODE_WRITE, 8'h41, 6'd0, 7'd0, 5'd0), 1'b1);
    send(mk(MODE_READ, 8'h00, 6'd0, 7'd0, 5'd0), 1'b1);
    send(mk(MODE_WRITE, 8'h00, 6'd63, 7'd127, 5'd31), 1'b1);
    send(mk(MODE_WRITE, 8'hff, 6'd0, 7'd0, 5'd0), 1'b1);
    send(mk(MODE_WRITE, CHAR_TAB, 6'd0, 7'd0, 5'd0), 1'b1);
    send(mk(MODE_WRITE, CHAR_NL, 6'd0, 7'd0, 5'd0), 1'b1);
    send(mk(MODE_SET_CURSOR, 8'h00, 6'd0, 7'd127, 5'd31), 1'b1);
    send(mk(MODE_WRITE, 8'h5a, 6'd0, 7'd0, 5'd0), 1'b1);
    send(mk(MODE_READ, 8'h00, 6'd0, 7'd127, 5'd23), 1'b1);
    send(mk(MODE_READ, 8'h00, 6'd0, 7'd127, 5'd31), 1'b1);
    send(mk(MODE_SET_CURSOR, 8'h00, 6'd0, 7'd78, 5'd3), 1'b1);
    send(mk(MODE_WRITE, CHAR_TAB, 6'd0, 7'd0, 5'd0), 1'b1);
    send(mk(MODE_SET_CURSOR, 8'h00, 6'd0, 7'd79, 5'd3), 1'b1);
    send(mk(MODE_WRITE, CHAR_TAB, 6'd0, 7'd0, 5'd0), 1'b1);
    send(mk(MODE_READ, 8'h00, 6'd0, 7'd79, 5'd3), 1'b1);
    send(mk(MODE_CLEAR_LINE, 8'h00, 6'd0, 7'd0, 5'd0), 1'b1);
    send(mk(MODE_CLEAR_LINE, 8'h00, 6'd63, 7'd0, 5'd0), 1'b1);
    send(mk(MODE_CLEAR_LINE, 8'h00, 6'd24, 7'd0, 5'd0), 1'b1);
    send(mk(MODE_SCROLL, 8'h00, 6'd0, 7'd0, 5'd0), 1'b1);
    send(mk(MODE_SCROLL, 8'h00, 6'd1, 7'd0, 5'd0), 1'b1);
    send(mk(MODE_READ, 8'h00, 6'd0, 7'd79, 5'd2), 1'b1);
    send(mk(MODE_SCROLL, 8'h00, 6'd63, 7'd0, 5'd0), 1'b1);
    send(mk(MODE_SPARE_A, 8'hff, 6'd63, 7'd127, 5'd31), 1'b1);
    send(mk(MODE_SPARE_B, 8'h00, 6'd0, 7'd0, 5'd0), 1'b1);
    send(mk(MODE_READ, 8'h00, 6'd0, 7'd0, 5'd0), 1'b1);

    run_phase(8'd1, 8'd1, 8'hff, 8'h00, 30, 1'b0, 1'b0, 1'b0);
    run_phase(8'd0, 8'd0, 8'ha5, 8'h5a, 20, 1'b0, 1'b0, 1'b0);
    run_phase(8'd8, 8'd4, 8'h3c, 8'hc3, 90, 1'b0, 1'b0, 1'b1);
    run_phase(8'hff, 8'hff, 8'h12, 8'hfe, 25, 1'b1, 1'b0, 1'b0);
    run_phase(8'd128, 8'd32, 8'h00, 8'hff, 20, 1'b1, 1'b0, 1'b0);
    run_phase(8'd5, 8'd3, 8'h81, 8'h7e, 90, 1'b0, 1'b0, 1'b0);
    run_phase(8'd13, 8'd7, 8'h55, 8'haa, 90, 1'b0, 1'b1, 1'b0);
    run_phase(8'd2, 8'd32, 8'h0f, 8'hf0, 40, 1'b0, 1'b0, 1'b0);
    run_phase(8'd128, 8'd1, 8'h99, 8'h66, 30, 1'b0, 1'b0, 1'b0);
    repeat (3)
      run_phase(8'($urandom_range(1, 20)), 8'($urandom_range(1, 10)),
                8'($urandom_range(255)), 8'($urandom_range(255)), 30, 1'b0, 1'b0, 1'b0);

    drain();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("text_console_writer: match");
    end else begin
      $display("text_console_writer: mismatch");
    end
    $finish;
  end

endmodule
